/* sv/itp_pkg.sv */
// Shared types, character codes and helper functions of the infix to postfix converter.
package itp_pkg;

   localparam int STACK_DEPTH_DEFAULT = 32;
   localparam int OP_W                = 3;
   localparam int SYM_W               = 8;

   localparam logic [SYM_W-1:0] CHAR_NUL   = 8'h00;
   localparam logic [SYM_W-1:0] CHAR_OPEN  = 8'h28;
   localparam logic [SYM_W-1:0] CHAR_CLOSE = 8'h29;
   localparam logic [SYM_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [SYM_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [SYM_W-1:0] CHAR_TIMES = 8'h2A;
   localparam logic [SYM_W-1:0] CHAR_DIV   = 8'h2F;

   typedef enum logic [OP_W-1:0] {
      OP_OPEN  = 3'd0,
      OP_PLUS  = 3'd1,
      OP_MINUS = 3'd2,
      OP_TIMES = 3'd3,
      OP_DIV   = 3'd4
   } op_code_type;

   typedef enum logic [1:0] {
      ERR_OK       = 2'd0,
      ERR_OVERFLOW = 2'd1,
      ERR_CLOSE    = 2'd2,
      ERR_OPEN     = 2'd3
   } err_type;

   typedef enum logic [2:0] {
      CLS_NUL,
      CLS_OPEN,
      CLS_CLOSE,
      CLS_LOW,
      CLS_HIGH,
      CLS_OPERAND
   } sym_class_type;

   typedef enum logic [1:0] {
      SEL_SYM,
      SEL_TOP,
      SEL_NUL
   } emit_sel_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic         load;
      logic         push;
      logic         pop;
      logic         emit;
      emit_sel_type sel;
      err_type      err;
      logic         last;
      logic         set_err3;
   } itp_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      sym_class_type cls;
      logic          eoe;
      logic          empty;
      logic          single;
      logic          full;
      op_code_type   top;
      op_code_type   below;
      logic          out_free;
   } itp_stat_type;

   function automatic sym_class_type classify(input logic [SYM_W-1:0] sym);
      sym_class_type cls;
      case (sym)
         CHAR_NUL:              cls = CLS_NUL;
         CHAR_OPEN:             cls = CLS_OPEN;
         CHAR_CLOSE:            cls = CLS_CLOSE;
         CHAR_PLUS, CHAR_MINUS: cls = CLS_LOW;
         CHAR_TIMES, CHAR_DIV:  cls = CLS_HIGH;
         default:               cls = CLS_OPERAND;
      endcase
      return cls;
   endfunction

   function automatic op_code_type sym_code(input logic [SYM_W-1:0] sym);
      op_code_type code;
      case (sym)
         CHAR_PLUS:  code = OP_PLUS;
         CHAR_MINUS: code = OP_MINUS;
         CHAR_TIMES: code = OP_TIMES;
         CHAR_DIV:   code = OP_DIV;
         default:    code = OP_OPEN;
      endcase
      return code;
   endfunction

   function automatic logic [SYM_W-1:0] op_char(input op_code_type code);
      logic [SYM_W-1:0] ch;
      case (code)
         OP_OPEN:  ch = CHAR_OPEN;
         OP_PLUS:  ch = CHAR_PLUS;
         OP_MINUS: ch = CHAR_MINUS;
         OP_TIMES: ch = CHAR_TIMES;
         OP_DIV:   ch = CHAR_DIV;
         default:  ch = CHAR_NUL;
      endcase
      return ch;
   endfunction

endpackage

/* sv/itp_req_if.sv */
// Input channel interface: one infix character per transaction.
interface itp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] symbol;
   logic       end_of_expression;

   modport source (output valid, output symbol, output end_of_expression, input ready);
   modport sink   (input valid, input symbol, input end_of_expression, output ready);
endinterface

/* sv/itp_rsp_if.sv */
// Result channel interface: one postfix character per transaction.
interface itp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_symbol;
   logic       last_of_run;
   logic [1:0] error_code;

   modport source (output valid, output out_symbol, output last_of_run, output error_code,
                   input ready);
   modport sink   (input valid, input out_symbol, input last_of_run, input error_code,
                   output ready);
endinterface

/* sv/itp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module itp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port, read-old-data read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* sv/itp_datapath.sv */
// Datapath: item registers, operator stack with top register, result register.
module itp_datapath
   import itp_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  itp_cmd_type      cmd,
   output itp_stat_type     stat,
   input  logic [SYM_W-1:0] req_symbol,
   input  logic             req_eoe,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [SYM_W-1:0] rsp_out_symbol,
   output logic             rsp_last_of_run,
   output logic [1:0]       rsp_error_code
);

   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int AW = $clog2(STACK_DEPTH);

   logic [SYM_W-1:0] sym_ff;
   logic             eoe_ff;
   logic             err3_ff;
   logic [CW-1:0]    count_ff, count_in;
   op_code_type      top_ff, top_in;
   logic             byp_ff;
   logic [OP_W-1:0]  byp_data_ff;
   logic             out_valid_ff;
   logic [SYM_W-1:0] out_sym_ff;
   logic             out_last_ff;
   err_type          out_err_ff;

   logic             ram_we;
   logic [AW-1:0]    ram_waddr;
   logic [AW-1:0]    ram_raddr;
   logic [OP_W-1:0]  ram_rdata;
   logic [OP_W-1:0]  below;
   logic [SYM_W-1:0] emit_sym;
   err_type          emit_err;

   // Hold the accepted transaction
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sym_ff <= req_symbol;
         eoe_ff <= req_eoe;
      end
   end

   // Track an open paren discarded while flushing
   always_ff @(posedge clock) begin
      if (reset) begin
         err3_ff <= 1'b0;
      end else if (cmd.load) begin
         err3_ff <= 1'b0;
      end else if (cmd.set_err3) begin
         err3_ff <= 1'b1;
      end
   end

   // Advance stack count and top register
   always_comb begin
      count_in = count_ff;
      top_in   = top_ff;
      if (cmd.push) begin
         count_in = count_ff + CW'(1);
         top_in   = sym_code(sym_ff);
      end else if (cmd.pop) begin
         count_in = count_ff - CW'(1);
         top_in   = op_code_type'(below);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      top_ff <= top_in;
   end

   // Spill the old top below the new one on a push; pre-read the entry under the top
   assign ram_we    = cmd.push && (count_ff != '0);
   assign ram_waddr = AW'(count_ff - CW'(1));
   assign ram_raddr = AW'(count_in - CW'(2));

   itp_ram #(
      .WIDTH (OP_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (top_ff),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // Forward an entry written in the same cycle it was read
   always_ff @(posedge clock) begin
      if (reset) begin
         byp_ff <= 1'b0;
      end else begin
         byp_ff <= ram_we && (ram_waddr == ram_raddr);
      end
      byp_data_ff <= top_ff;
   end

   assign below = byp_ff ? byp_data_ff : ram_rdata;

   // Select the result to emit
   always_comb begin
      case (cmd.sel)
         SEL_SYM: emit_sym = sym_ff;
         SEL_TOP: emit_sym = op_char(top_ff);
         SEL_NUL: emit_sym = CHAR_NUL;
         default: emit_sym = CHAR_NUL;
      endcase
      if (cmd.sel == SEL_NUL) begin
         emit_err = err3_ff ? ERR_OPEN : ERR_OK;
      end else begin
         emit_err = cmd.err;
      end
   end

   // Result register: load on emit, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
      if (cmd.emit) begin
         out_sym_ff  <= emit_sym;
         out_last_ff <= cmd.last;
         out_err_ff  <= emit_err;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_out_symbol  = out_sym_ff;
   assign rsp_last_of_run = out_last_ff;
   assign rsp_error_code  = out_err_ff;

   // Status to the controller
   assign stat.cls      = classify(sym_ff);
   assign stat.eoe      = eoe_ff;
   assign stat.empty    = (count_ff == '0);
   assign stat.single   = (count_ff == CW'(1));
   assign stat.full     = (count_ff == CW'(STACK_DEPTH));
   assign stat.top      = top_ff;
   assign stat.below    = op_code_type'(below);
   assign stat.out_free = !out_valid_ff || rsp_ready;

endmodule

/* sv/itp_controller.sv */
// Controller: sequences accept, operator handling and end-of-expression flush.
module itp_controller
   import itp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  itp_stat_type stat,
   output itp_cmd_type  cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_PROC,
      S_FLUSH
   } state_type;

   state_type state_ff, state_in;
   logic      done;
   logic      high_top;
   logic      high_below;

   assign high_top   = (stat.top == OP_TIMES) || (stat.top == OP_DIV);
   assign high_below = (stat.below == OP_TIMES) || (stat.below == OP_DIV);

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Decode next step and commands
   always_comb begin
      state_in     = state_ff;
      req_ready    = 1'b0;
      done         = 1'b0;
      cmd.load     = 1'b0;
      cmd.push     = 1'b0;
      cmd.pop      = 1'b0;
      cmd.emit     = 1'b0;
      cmd.sel      = SEL_SYM;
      cmd.err      = ERR_OK;
      cmd.last     = 1'b0;
      cmd.set_err3 = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_PROC;
            end
         end
         S_PROC: begin
            case (stat.cls)
               CLS_OPEN: begin
                  if (stat.full) begin
                     if (stat.out_free) begin
                        cmd.emit = 1'b1;
                        cmd.err  = ERR_OVERFLOW;
                        cmd.last = !stat.eoe;
                        done     = 1'b1;
                     end
                  end else begin
                     cmd.push = 1'b1;
                     done     = 1'b1;
                  end
               end
               CLS_CLOSE: begin
                  if (!stat.empty && stat.top != OP_OPEN) begin
                     if (stat.out_free) begin
                        cmd.emit = 1'b1;
                        cmd.sel  = SEL_TOP;
                        cmd.pop  = 1'b1;
                        cmd.last = !stat.eoe && !stat.single && stat.below == OP_OPEN;
                     end
                  end else if (!stat.empty) begin
                     cmd.pop = 1'b1;
                     done    = 1'b1;
                  end else if (stat.out_free) begin
                     cmd.emit = 1'b1;
                     cmd.err  = ERR_CLOSE;
                     cmd.last = !stat.eoe;
                     done     = 1'b1;
                  end
               end
               CLS_LOW: begin
                  if (!stat.empty && stat.top != OP_OPEN) begin
                     if (stat.out_free) begin
                        cmd.emit = 1'b1;
                        cmd.sel  = SEL_TOP;
                        cmd.pop  = 1'b1;
                        cmd.last = !stat.eoe && (stat.single || stat.below == OP_OPEN);
                     end
                  end else if (stat.full) begin
                     if (stat.out_free) begin
                        cmd.emit = 1'b1;
                        cmd.err  = ERR_OVERFLOW;
                        cmd.last = !stat.eoe;
                        done     = 1'b1;
                     end
                  end else begin
                     cmd.push = 1'b1;
                     done     = 1'b1;
                  end
               end
               CLS_HIGH: begin
                  if (!stat.empty && high_top) begin
                     if (stat.out_free) begin
                        cmd.emit = 1'b1;
                        cmd.sel  = SEL_TOP;
                        cmd.pop  = 1'b1;
                        cmd.last = !stat.eoe && (stat.single || !high_below);
                     end
                  end else if (stat.full) begin
                     if (stat.out_free) begin
                        cmd.emit = 1'b1;
                        cmd.err  = ERR_OVERFLOW;
                        cmd.last = !stat.eoe;
                        done     = 1'b1;
                     end
                  end else begin
                     cmd.push = 1'b1;
                     done     = 1'b1;
                  end
               end
               CLS_OPERAND: begin
                  if (stat.out_free) begin
                     cmd.emit = 1'b1;
                     cmd.last = !stat.eoe;
                     done     = 1'b1;
                  end
               end
               default: begin
                  done = 1'b1;
               end
            endcase
            if (done) begin
               state_in = stat.eoe ? S_FLUSH : S_IDLE;
            end
         end
         S_FLUSH: begin
            if (!stat.empty) begin
               if (stat.top == OP_OPEN) begin
                  cmd.pop      = 1'b1;
                  cmd.set_err3 = 1'b1;
               end else if (stat.out_free) begin
                  cmd.emit = 1'b1;
                  cmd.sel  = SEL_TOP;
                  cmd.pop  = 1'b1;
               end
            end else if (stat.out_free) begin
               cmd.emit = 1'b1;
               cmd.sel  = SEL_NUL;
               cmd.last = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

/* sv/infix_to_postfix_converter_core.sv */
// The accepted character is held in the item register; a character that is emitted at once
// is then loaded into the result register; a push or a stalled result ahead of it delays it.
// Each character takes an accept step and a step per operator popped, symbol emitted, push
// made or NUL; the end flag adds a step per flushed entry and the terminator; stalls add theirs.
// Reset (synchronous, active high) empties the stack, idles the controller and drops any
// pending result; the stack RAM contents are not cleared and need no clearing pass.
module infix_to_postfix_converter_core
   import itp_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   itp_req_if.sink       req_chan,
   itp_rsp_if.source     rsp_chan
);

   itp_cmd_type  cmd;
   itp_stat_type stat;

   itp_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   itp_datapath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_symbol      (req_chan.symbol),
      .req_eoe         (req_chan.end_of_expression),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_out_symbol  (rsp_chan.out_symbol),
      .rsp_last_of_run (rsp_chan.last_of_run),
      .rsp_error_code  (rsp_chan.error_code)
   );

endmodule

/* sv/itp_checker.sv */
// Port-level checker of the infix to postfix converter, bound to the top level.
module itp_checker
   import itp_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [SYM_W-1:0] rsp_out_symbol,
   input logic             rsp_last_of_run,
   input logic [1:0]       rsp_error_code
);

   // Hold a stalled result transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_symbol)
         && $stable(rsp_last_of_run) && $stable(rsp_error_code))
      else $error("result changed while stalled");

   // One transaction at a time: no accept in the cycle after an accept
   a_req_single: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input accepted while previous transaction in progress");

   // Terminator always closes the run
   a_nul_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_symbol == CHAR_NUL |-> rsp_last_of_run)
      else $error("terminator without last_of_run");

   // Error codes travel with their own characters
   a_err_sym: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_error_code != ERR_OPEN || rsp_out_symbol == CHAR_NUL)
         && (rsp_error_code != ERR_CLOSE || rsp_out_symbol == CHAR_CLOSE))
      else $error("error code on wrong character");

endmodule

bind infix_to_postfix_converter_core itp_checker u_itp_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_out_symbol  (rsp_chan.out_symbol),
   .rsp_last_of_run (rsp_chan.last_of_run),
   .rsp_error_code  (rsp_chan.error_code)
);

/* verif/tb_infix_to_postfix_converter_core.sv */
// Self-checking testbench for the infix to postfix converter core, with random handshake stalls.
module tb_infix_to_postfix_converter_core;
   timeunit 1ns;
   timeprecision 1ps;

   import itp_pkg::*;

   localparam int DEPTH        = STACK_DEPTH_DEFAULT;
   localparam int TARGET_ITEMS = 470;
   localparam int DIRECTED_N   = 25;

   // Character emitted when an operator of each code leaves the stack
   localparam logic [7:0] OP_SYMBOL [5] = '{CHAR_OPEN, CHAR_PLUS, CHAR_MINUS, CHAR_TIMES,
                                            CHAR_DIV};

   typedef struct packed {
      logic [7:0] sym;
      logic       last;
      err_type    err;
   } postfix_char_type;

   // How a directed row is checked: by the predictor, or by a typed-in result
   typedef enum {BY_MODEL, NO_RESULT, ONE_RESULT} row_check_type;

   typedef struct {
      logic [7:0]    sym;
      logic          eoe;
      int            reps;
      row_check_type kind;
      logic [7:0]    exp_sym;
      err_type       exp_err;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset;

   itp_req_if req_chan ();
   itp_rsp_if rsp_chan ();

   infix_to_postfix_converter_core #(
      .STACK_DEPTH (DEPTH)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Predictor state
   op_code_type      op_stack [DEPTH];
   int               op_depth;
   postfix_char_type run_q [$];
   postfix_char_type postfix_q [$];

   // Stimulus state
   logic [7:0]       expr_chars [$];
   directed_row_type directed_rows [DIRECTED_N];
   bit               req_idling;
   bit               rsp_idling;
   int               counted_items;
   int               mismatch_count;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Limit on the whole run
   initial begin
      #20_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t ns: %s", $time, what);
      mismatch_count++;
   endtask

   function automatic int draw_gap(input bit idling);
      return idling ? int'($urandom_range(0, 13)) : 0;
   endfunction

   // Predictor: pop the top operator to the output
   function automatic void pop_op();
      run_q.push_back('{OP_SYMBOL[op_stack[op_depth-1]], 1'b0, ERR_OK});
      op_depth--;
   endfunction

   // Predictor: push an operator, or flag the dropped character when full
   function automatic void push_op(input op_code_type code, input logic [7:0] sym);
      if (op_depth >= DEPTH) begin
         run_q.push_back('{sym, 1'b0, ERR_OVERFLOW});
      end else begin
         op_stack[op_depth] = code;
         op_depth++;
      end
   endfunction

   // Predictor: postfix characters caused by one infix character, left in run_q
   function automatic void convert_char(input logic [7:0] sym, input logic eoe);
      err_type flush_err;
      flush_err = ERR_OK;
      run_q = {};
      case (sym)
         CHAR_NUL: begin
         end
         CHAR_OPEN: begin
            push_op(OP_OPEN, sym);
         end
         CHAR_CLOSE: begin
            while (op_depth > 0 && op_stack[op_depth-1] != OP_OPEN) pop_op();
            if (op_depth > 0) op_depth--;
            else run_q.push_back('{sym, 1'b0, ERR_CLOSE});
         end
         CHAR_PLUS, CHAR_MINUS: begin
            while (op_depth > 0 && op_stack[op_depth-1] != OP_OPEN) pop_op();
            push_op((sym == CHAR_PLUS) ? OP_PLUS : OP_MINUS, sym);
         end
         CHAR_TIMES, CHAR_DIV: begin
            while (op_depth > 0 && (op_stack[op_depth-1] == OP_TIMES ||
                                    op_stack[op_depth-1] == OP_DIV)) pop_op();
            push_op((sym == CHAR_TIMES) ? OP_TIMES : OP_DIV, sym);
         end
         default: begin
            run_q.push_back('{sym, 1'b0, ERR_OK});
         end
      endcase
      // Flush the stack on the end flag; a left-over '(' is dropped and flagged
      if (eoe) begin
         while (op_depth > 0) begin
            if (op_stack[op_depth-1] == OP_OPEN) begin
               flush_err = ERR_OPEN;
               op_depth--;
            end else begin
               pop_op();
            end
         end
         run_q.push_back('{CHAR_NUL, 1'b0, flush_err});
      end
      if (run_q.size() > 0) run_q[run_q.size()-1].last = 1'b1;
   endfunction

   // Drive one character and record what it should produce once accepted
   task automatic send_char(input logic [7:0] sym, input logic eoe, input row_check_type kind,
                            input logic [7:0] exp_sym, input err_type exp_err);
      int gap;
      gap = draw_gap(req_idling);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid             <= 1'b1;
      req_chan.symbol            <= sym;
      req_chan.end_of_expression <= eoe;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      convert_char(sym, eoe);
      case (kind)
         BY_MODEL:   foreach (run_q[i]) postfix_q.push_back(run_q[i]);
         NO_RESULT:  ;
         ONE_RESULT: postfix_q.push_back('{exp_sym, 1'b1, exp_err});
      endcase
      if (sym != CHAR_NUL || eoe) counted_items++;
   endtask

   // Hold the sender until every expected result has come back
   task automatic wait_for_postfix_drain();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (postfix_q.size() != 0);
   endtask

   function automatic bit is_special(input logic [7:0] sym);
      case (sym)
         CHAR_NUL, CHAR_OPEN, CHAR_CLOSE, CHAR_PLUS, CHAR_MINUS, CHAR_TIMES, CHAR_DIV: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   function automatic logic [7:0] pick_operand();
      logic [7:0] sym;
      // Mostly lower-case letters, otherwise any plain character
      if ($urandom_range(0, 3) != 0) return 8'h61 + 8'($urandom_range(0, 25));
      do sym = 8'($urandom_range(1, 255)); while (is_special(sym));
      return sym;
   endfunction

   function automatic logic [7:0] pick_operator();
      case ($urandom_range(0, 3))
         0:       return CHAR_PLUS;
         1:       return CHAR_MINUS;
         2:       return CHAR_TIMES;
         default: return CHAR_DIV;
      endcase
   endfunction

   function automatic logic [7:0] pick_noise();
      case ($urandom_range(0, 7))
         0:       return CHAR_OPEN;
         1:       return CHAR_CLOSE;
         2:       return CHAR_PLUS;
         3:       return CHAR_MINUS;
         4:       return CHAR_TIMES;
         5:       return CHAR_DIV;
         6:       return CHAR_NUL;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Well-formed expression: terms joined by operators, terms may be bracketed
   function automatic void gen_term(input int nest);
      if (nest > 0 && $urandom_range(0, 3) == 0) begin
         expr_chars.push_back(CHAR_OPEN);
         gen_expr(nest - 1);
         expr_chars.push_back(CHAR_CLOSE);
      end else begin
         expr_chars.push_back(pick_operand());
      end
   endfunction

   function automatic void gen_expr(input int nest);
      int n_ops;
      n_ops = $urandom_range(0, 4);
      gen_term(nest);
      repeat (n_ops) begin
         expr_chars.push_back(pick_operator());
         gen_term(nest);
      end
   endfunction

   // Result side: stall at random, compare each transaction with the oldest expectation
   initial begin
      postfix_char_type want;
      int               gap;
      do @(posedge clock); while (reset);
      forever begin
         gap = draw_gap(rsp_idling);
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_chan.valid) @(posedge clock);
         if (postfix_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result %02h", rsp_chan.out_symbol));
         end else begin
            want = postfix_q.pop_front();
            if (rsp_chan.out_symbol !== want.sym)
               report_mismatch($sformatf("out_symbol %02h, want %02h",
                                         rsp_chan.out_symbol, want.sym));
            if (rsp_chan.last_of_run !== want.last)
               report_mismatch($sformatf("last_of_run %b, want %b on %02h",
                                         rsp_chan.last_of_run, want.last, want.sym));
            if (rsp_chan.error_code !== want.err)
               report_mismatch($sformatf("error_code %0d, want %0d on %02h",
                                         rsp_chan.error_code, want.err, want.sym));
         end
      end
   end

   // Stimulus
   initial begin
      int  pick;
      int  chunks;
      bit  flush_last;
      reset                      = 1'b1;
      req_chan.valid             = 1'b0;
      req_chan.symbol            = CHAR_NUL;
      req_chan.end_of_expression = 1'b0;
      rsp_chan.ready             = 1'b0;
      op_depth                   = 0;
      mismatch_count             = 0;
      counted_items              = 0;
      req_idling                 = 1'b1;
      rsp_idling                 = 1'b1;

      directed_rows = '{
         // unmatched close on an empty stack, lone NUL, NUL as terminator
         '{CHAR_CLOSE, 1'b0, 1, ONE_RESULT, CHAR_CLOSE, ERR_CLOSE},
         '{CHAR_NUL,   1'b0, 1, NO_RESULT,  CHAR_NUL,   ERR_OK},
         '{CHAR_NUL,   1'b1, 1, ONE_RESULT, CHAR_NUL,   ERR_OK},
         // operand extremes
         '{8'hFF,      1'b0, 1, ONE_RESULT, 8'hFF,      ERR_OK},
         '{8'h01,      1'b0, 1, ONE_RESULT, 8'h01,      ERR_OK},
         // unmatched open parens found by the flush
         '{CHAR_OPEN,  1'b0, 1, NO_RESULT,  CHAR_NUL,   ERR_OK},
         '{CHAR_OPEN,  1'b1, 1, ONE_RESULT, CHAR_NUL,   ERR_OPEN},
         // a+b*c-d/e with the flush on the last operand
         '{"a",        1'b0, 1, BY_MODEL,   CHAR_NUL,   ERR_OK},
         '{CHAR_PLUS,  1'b0, 1, BY_MODEL,   CHAR_NUL,   ERR_OK},
         '{"b",        1'b0, 1, BY_MODEL,   CHAR_NUL,   ERR_OK},
         '{CHAR_TIMES, 1'b0, 1, BY_MODEL,   CHAR_NUL,   ERR_OK},
         '{"c",        1'b0, 1, BY_MODEL,   CHAR_NUL,   ERR_OK},
         '{CHAR_MINUS, 1'b0, 1, BY_MODEL,   CHAR_NUL,   ERR_OK},
         '{"d",        1'b0, 1, BY_MODEL,   CHAR_NUL,   ERR_OK},
         '{CHAR_DIV,   1'b0, 1, BY_MODEL,   CHAR_NUL,   ERR_OK},
         '{"e",        1'b1, 1, BY_MODEL,   CHAR_NUL,   ERR_OK},
         // close paren that pops an operator and then finds no open
         '{"x",        1'b0, 1, BY_MODEL,   CHAR_NUL,   ERR_OK},
         '{CHAR_MINUS, 1'b0, 1, BY_MODEL,   CHAR_NUL,   ERR_OK},
         '{CHAR_CLOSE, 1'b0, 1, BY_MODEL,   CHAR_NUL,   ERR_OK},
         // fill the stack, then overflow with both operator classes
         '{CHAR_OPEN,  1'b0, DEPTH, NO_RESULT, CHAR_NUL, ERR_OK},
         '{CHAR_TIMES, 1'b0, 1, ONE_RESULT, CHAR_TIMES, ERR_OVERFLOW},
         '{CHAR_PLUS,  1'b0, 1, ONE_RESULT, CHAR_PLUS,  ERR_OVERFLOW},
         '{CHAR_CLOSE, 1'b0, 1, NO_RESULT,  CHAR_NUL,   ERR_OK},
         // flush of a full stack, then a close paren with the end flag
         '{CHAR_DIV,   1'b1, 1, BY_MODEL,   CHAR_NUL,   ERR_OK},
         '{CHAR_CLOSE, 1'b1, 1, BY_MODEL,   CHAR_NUL,   ERR_OK}
      };

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part
      foreach (directed_rows[r])
         repeat (directed_rows[r].reps)
            send_char(directed_rows[r].sym, directed_rows[r].eoe, directed_rows[r].kind,
                      directed_rows[r].exp_sym, directed_rows[r].exp_err);
      wait_for_postfix_drain();

      // Random part: mostly well-formed expressions, some noise and deep nesting
      chunks = 0;
      while (counted_items < TARGET_ITEMS) begin
         req_idling = ($urandom_range(0, 2) != 0);
         rsp_idling = ($urandom_range(0, 2) != 0);
         expr_chars = {};
         flush_last = 1'b1;
         pick       = $urandom_range(0, 19);
         if (pick < 14) begin
            gen_expr($urandom_range(0, 3));
            // sometimes end on a separate NUL that carries the end flag
            if ($urandom_range(0, 5) == 0) expr_chars.push_back(CHAR_NUL);
         end else if (pick < 18) begin
            repeat ($urandom_range(3, 12)) expr_chars.push_back(pick_noise());
            flush_last = $urandom_range(0, 1);
         end else begin
            repeat ($urandom_range(DEPTH - 4, DEPTH + 8)) begin
               expr_chars.push_back(CHAR_OPEN);
               if ($urandom_range(0, 3) == 0) expr_chars.push_back(pick_operator());
            end
            expr_chars.push_back(pick_operand());
            repeat ($urandom_range(0, 6)) expr_chars.push_back(CHAR_CLOSE);
         end
         foreach (expr_chars[i])
            send_char(expr_chars[i], flush_last && (i == expr_chars.size() - 1),
                      BY_MODEL, CHAR_NUL, ERR_OK);
         chunks++;
         if (chunks % 9 == 0) wait_for_postfix_drain();
      end

      // Wait out the last results, then allow for any stray ones
      req_chan.valid <= 1'b0;
      while (postfix_q.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

/* sim.f */
sv/itp_pkg.sv
sv/itp_req_if.sv
sv/itp_rsp_if.sv
sv/itp_ram.sv
sv/itp_datapath.sv
sv/itp_controller.sv
sv/infix_to_postfix_converter_core.sv
sv/itp_checker.sv
verif/tb_infix_to_postfix_converter_core.sv
